FILE: design/asd_pkg.sv
package asd_pkg;

    localparam int WINDOW_LEN_DEF = 8;
    localparam int MAG_W          = 15;
    localparam int ACC_W          = 16;
    localparam int TIME_W         = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [MAG_W-1:0] MAG_MAX      = 15'd32767;
    localparam logic [MAG_W-1:0] THRESH_RESET = 15'd1200;
    localparam logic [7:0]       ACTIVE_MAX   = 8'd255;

    localparam logic [11:0] GRAVITY_RESET   = 12'd1000;
    localparam logic [11:0] NOISE_RESET     = 12'd200;
    localparam logic [14:0] ACTIVE_RESET    = 15'd800;
    localparam logic [15:0] GAP_RESET       = 16'd200;
    localparam logic [14:0] FLOOR_RESET     = 15'd800;
    localparam logic [9:0]  RAISE_RESET     = 10'd50;
    localparam logic [9:0]  LOWER_RESET     = 10'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAVITY = 3'd0,
        CFG_NOISE   = 3'd1,
        CFG_ACTIVE  = 3'd2,
        CFG_GAP     = 3'd3,
        CFG_FLOOR   = 3'd4,
        CFG_RAISE   = 3'd5,
        CFG_LOWER   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [11:0] gravity_offset;
        logic [11:0] noise_floor;
        logic [14:0] active_level;
        logic [15:0] min_step_gap_ms;
        logic [14:0] threshold_floor;
        logic [9:0]  raise_amount;
        logic [9:0]  lower_amount;
    } t_cfg;

    typedef struct packed {
        logic              step_seen;
        logic [31:0]       steps_total;
        logic [7:0]        active_total;
        logic [MAG_W-1:0]  current_threshold;
        logic [MAG_W-1:0]  deviation;
    } t_result;

endpackage

FILE: design/asd_win_cell.sv
module asd_win_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_shift,
    input  logic [asd_pkg::MAG_W-1:0]   i_data,
    output logic [asd_pkg::MAG_W-1:0]   o_data
);

    logic [asd_pkg::MAG_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

FILE: design/asd_window.sv
module asd_window #(
    parameter int WINDOW_LEN = asd_pkg::WINDOW_LEN_DEF,
    parameter int TOT_W      = asd_pkg::MAG_W + $clog2(WINDOW_LEN)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_shift,
    input  logic [asd_pkg::MAG_W-1:0]   i_mag,
    output logic [TOT_W-1:0]            o_total
);

    logic [asd_pkg::MAG_W-1:0] tap [WINDOW_LEN+1];
    logic [TOT_W-1:0]          r_total;
    logic [TOT_W-1:0]          n_total;

    assign tap[0] = i_mag;

    // newest sample at the head, oldest drops off the far end
    for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_cell
        asd_win_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_shift),
            .i_data  (tap[g]),
            .o_data  (tap[g+1])
        );
    end

    assign n_total = r_total - TOT_W'(tap[WINDOW_LEN]) + TOT_W'(i_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_shift) begin
            r_total <= n_total;
        end
    end

    assign o_total = r_total;

endmodule

FILE: design/asd_tracker.sv
module asd_tracker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_valid,
    input  asd_pkg::t_cfg                i_cfg,
    input  logic [asd_pkg::MAG_W-1:0]    i_dev,
    input  logic [asd_pkg::TIME_W-1:0]   i_time,
    input  logic                         i_clear,
    output asd_pkg::t_result             o_res
);

    logic [asd_pkg::MAG_W-1:0]  r_thr;
    logic [asd_pkg::TIME_W-1:0] r_last;
    logic [31:0]                r_steps;
    logic [7:0]                 r_active;
    logic                       r_rearm;
    asd_pkg::t_result           r_res;

    logic [7:0]                 n_active;
    logic [31:0]                n_steps;
    logic [asd_pkg::MAG_W-1:0]  n_thr;
    logic                       n_rearm;
    logic                       hit;
    logic [asd_pkg::TIME_W-1:0] elapsed;
    logic [15:0]                raised;
    logic [16:0]                thr_x3;
    logic [16:0]                new_x3;
    logic                       big_step;
    logic                       small_step;
    logic [asd_pkg::MAG_W-1:0]  lowered;

    always_comb begin
        n_active = r_active;
        if (i_dev > i_cfg.active_level && r_active != asd_pkg::ACTIVE_MAX) begin
            n_active = r_active + 8'd1;
        end

        elapsed = i_time - r_last;
        hit     = (i_dev > r_thr) && r_rearm && (elapsed > 32'(i_cfg.min_step_gap_ms));
        n_steps = hit ? r_steps + 32'd1 : r_steps;

        thr_x3     = 17'(r_thr) + {1'b0, r_thr, 1'b0};
        big_step   = {1'b0, i_dev} > {r_thr, 1'b0};
        small_step = (r_thr > i_cfg.threshold_floor) && ({1'b0, i_dev} < thr_x3[16:1]);
        raised     = 16'(r_thr) + 16'(i_cfg.raise_amount);
        lowered    = (r_thr > 15'(i_cfg.lower_amount)) ?
                     r_thr - 15'(i_cfg.lower_amount) : '0;

        n_thr = r_thr;
        if (hit) begin
            if (big_step) begin
                n_thr = raised[15] ? asd_pkg::MAG_MAX : raised[14:0];
            end else if (small_step) begin
                n_thr = lowered;
            end
        end

        // rearm compares against the threshold after this beat's update
        new_x3  = 17'(n_thr) + {1'b0, n_thr, 1'b0};
        n_rearm = 17'(i_dev) < {2'b00, new_x3[16:2]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= asd_pkg::THRESH_RESET;
            r_last   <= '0;
            r_steps  <= '0;
            r_active <= '0;
            r_rearm  <= 1'b0;
        end else if (i_adv && i_valid) begin
            r_thr    <= n_thr;
            r_rearm  <= n_rearm;
            if (hit) begin
                r_last <= i_time;
            end
            r_steps  <= i_clear ? '0 : n_steps;
            r_active <= i_clear ? '0 : n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_res.step_seen         <= hit;
            r_res.steps_total       <= n_steps;
            r_res.active_total      <= n_active;
            r_res.current_threshold <= n_thr;
            r_res.deviation         <= i_dev;
        end
    end

    assign o_res = r_res;

endmodule

FILE: design/adaptive_step_detector.sv
// Pipeline of six register stages; a result beat is offered once its sample has passed all six.
// Throughput is one sample per cycle; the whole pipeline holds only while the output beat waits.
// The window is a chain of WINDOW_LEN shift cells plus a running total; the threshold
// and counters update in one stage, so consecutive samples never wait on each other.
// Synchronous active-low reset clears the window, counters, threshold (1200) and the
// configuration registers to their defaults; configuration writes are accepted every cycle outside reset.
module adaptive_step_detector #(
    parameter int WINDOW_LEN = asd_pkg::WINDOW_LEN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [asd_pkg::ACC_W-1:0]  i_accel_x,
    input  logic signed [asd_pkg::ACC_W-1:0]  i_accel_y,
    input  logic signed [asd_pkg::ACC_W-1:0]  i_accel_z,
    input  logic [asd_pkg::TIME_W-1:0]        i_time_ms,
    input  logic                              i_clear_counts,

    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_step_seen,
    output logic [31:0]                       o_steps_total,
    output logic [7:0]                        o_active_total,
    output logic [asd_pkg::MAG_W-1:0]         o_current_threshold,
    output logic [asd_pkg::MAG_W-1:0]         o_deviation,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [asd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [asd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int TOT_W   = asd_pkg::MAG_W + $clog2(WINDOW_LEN);
    // exact divide by the window length: ceil reciprocal with enough fraction bits
    localparam int SH      = TOT_W + 7;
    localparam longint RECIP   = ((64'd1 << SH) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = TOT_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

    asd_pkg::t_cfg    r_cfg;
    asd_pkg::t_result res;

    logic adv;
    logic r_va, r_vb, r_vc, r_vd, r_ve, r_out_valid;

    logic [asd_pkg::ACC_W-1:0]  abs_x, abs_y, abs_z;
    logic [31:0]                r_sq_x, r_sq_y, r_sq_z;
    logic [31:0]                sq_sum;
    logic [asd_pkg::MAG_W-1:0]  r_mag_b;
    logic [TOT_W-1:0]           total;
    logic [PROD_W-1:0]          r_prod_d;
    logic [asd_pkg::MAG_W-1:0]  avg;
    logic [asd_pkg::MAG_W-1:0]  diff;
    logic [asd_pkg::MAG_W-1:0]  r_dev_e;

    logic [asd_pkg::TIME_W-1:0] r_time_a, r_time_b, r_time_c, r_time_d, r_time_e;
    logic                       r_clr_a, r_clr_b, r_clr_c, r_clr_d, r_clr_e;

    assign adv         = !r_out_valid || i_out_ready;
    assign o_in_ready  = adv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va        <= 1'b0;
            r_vb        <= 1'b0;
            r_vc        <= 1'b0;
            r_vd        <= 1'b0;
            r_ve        <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg.gravity_offset  <= asd_pkg::GRAVITY_RESET;
            r_cfg.noise_floor     <= asd_pkg::NOISE_RESET;
            r_cfg.active_level    <= asd_pkg::ACTIVE_RESET;
            r_cfg.min_step_gap_ms <= asd_pkg::GAP_RESET;
            r_cfg.threshold_floor <= asd_pkg::FLOOR_RESET;
            r_cfg.raise_amount    <= asd_pkg::RAISE_RESET;
            r_cfg.lower_amount    <= asd_pkg::LOWER_RESET;
        end else begin
            if (adv) begin
                r_va        <= i_in_valid;
                r_vb        <= r_va;
                r_vc        <= r_vb;
                r_vd        <= r_vc;
                r_ve        <= r_vd;
                r_out_valid <= r_ve;
            end
            if (i_cfg_valid) begin
                unique case (asd_pkg::t_cfg_idx'(i_cfg_index))
                    asd_pkg::CFG_GRAVITY: r_cfg.gravity_offset  <= i_cfg_data[11:0];
                    asd_pkg::CFG_NOISE:   r_cfg.noise_floor     <= i_cfg_data[11:0];
                    asd_pkg::CFG_ACTIVE:  r_cfg.active_level    <= i_cfg_data[14:0];
                    asd_pkg::CFG_GAP:     r_cfg.min_step_gap_ms <= i_cfg_data;
                    asd_pkg::CFG_FLOOR:   r_cfg.threshold_floor <= i_cfg_data[14:0];
                    asd_pkg::CFG_RAISE:   r_cfg.raise_amount    <= i_cfg_data[9:0];
                    asd_pkg::CFG_LOWER:   r_cfg.lower_amount    <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
        end
    end

    // most negative input folds to 0x8000, still correct as unsigned
    assign abs_x = i_accel_x[15] ? 16'(-i_accel_x) : i_accel_x;
    assign abs_y = i_accel_y[15] ? 16'(-i_accel_y) : i_accel_y;
    assign abs_z = i_accel_z[15] ? 16'(-i_accel_z) : i_accel_z;

    assign sq_sum = r_sq_x + r_sq_y + r_sq_z;

    always_comb begin
        avg  = r_prod_d[SH +: asd_pkg::MAG_W];
        diff = (avg >= 15'(r_cfg.gravity_offset)) ? avg - 15'(r_cfg.gravity_offset)
                                                 : 15'(r_cfg.gravity_offset) - avg;
        if (diff < 15'(r_cfg.noise_floor)) begin
            diff = 15'(r_cfg.noise_floor);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq_x   <= abs_x * abs_x;
            r_sq_y   <= abs_y * abs_y;
            r_sq_z   <= abs_z * abs_z;
            r_time_a <= i_time_ms;
            r_clr_a  <= i_clear_counts;

            r_mag_b  <= (sq_sum[31:10] > 22'(asd_pkg::MAG_MAX)) ? asd_pkg::MAG_MAX
                                                              : sq_sum[24:10];
            r_time_b <= r_time_a;
            r_clr_b  <= r_clr_a;

            r_time_c <= r_time_b;
            r_clr_c  <= r_clr_b;

            r_prod_d <= PROD_W'(total) * PROD_W'(RECIP_V);
            r_time_d <= r_time_c;
            r_clr_d  <= r_clr_c;

            r_dev_e  <= diff;
            r_time_e <= r_time_d;
            r_clr_e  <= r_clr_d;
        end
    end

    asd_window #(
        .WINDOW_LEN (WINDOW_LEN),
        .TOT_W      (TOT_W)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (adv && r_vb),
        .i_mag   (r_mag_b),
        .o_total (total)
    );

    asd_tracker u_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_ve),
        .i_cfg   (r_cfg),
        .i_dev   (r_dev_e),
        .i_time  (r_time_e),
        .i_clear (r_clr_e),
        .o_res   (res)
    );

    assign o_step_seen         = res.step_seen;
    assign o_steps_total       = res.steps_total;
    assign o_active_total      = res.active_total;
    assign o_current_threshold = res.current_threshold;
    assign o_deviation         = res.deviation;

endmodule

FILE: tb/adaptive_step_detector_tb.sv
`timescale 1ns / 100ps

module adaptive_step_detector_tb;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RX_HOLD_AT      = 300;
    localparam int RX_HOLD_CYCLES  = 60;
    localparam logic [asd_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_ready;
    logic signed [asd_pkg::ACC_W-1:0]    i_accel_x;
    logic signed [asd_pkg::ACC_W-1:0]    i_accel_y;
    logic signed [asd_pkg::ACC_W-1:0]    i_accel_z;
    logic [asd_pkg::TIME_W-1:0]          i_time_ms;
    logic                                i_clear_counts;
    logic                                o_out_valid;
    logic                                i_out_ready;
    logic                                o_step_seen;
    logic [31:0]                         o_steps_total;
    logic [7:0]                          o_active_total;
    logic [asd_pkg::MAG_W-1:0]           o_current_threshold;
    logic [asd_pkg::MAG_W-1:0]           o_deviation;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [asd_pkg::CFG_IDX_W-1:0]       i_cfg_index;
    logic [asd_pkg::CFG_DATA_W-1:0]      i_cfg_data;

    adaptive_step_detector DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_accel_x           (i_accel_x),
        .i_accel_y           (i_accel_y),
        .i_accel_z           (i_accel_z),
        .i_time_ms           (i_time_ms),
        .i_clear_counts      (i_clear_counts),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_step_seen         (o_step_seen),
        .o_steps_total       (o_steps_total),
        .o_active_total      (o_active_total),
        .o_current_threshold (o_current_threshold),
        .o_deviation         (o_deviation),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // Detector state mirrored in the bench
    asd_pkg::t_cfg model_cfg;
    int          win_mag [asd_pkg::WINDOW_LEN_DEF];
    int          win_idx;
    int          win_sum;
    int          thr_lvl;
    logic [31:0] prev_step_ms;
    logic [31:0] step_cnt;
    int          active_cnt;
    logic        armed;

    asd_pkg::t_result expected_q [$];
    int          errors;
    int          results_seen;
    int          cycles;
    logic        tx_fast;
    logic        rx_fast;

    // Walk generator state
    logic [31:0] walk_ms;
    int          walk_pos;
    int          walk_period;
    int          walk_peak_len;
    real         walk_gain;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [31:0]        t;
        logic               clr;
        logic               typed;
        asd_pkg::t_result   res;
    } t_stim_row;

    t_stim_row   stim_rows [$];

    function automatic asd_pkg::t_result predict_sample(input logic signed [15:0] ax,
                                                        input logic signed [15:0] ay,
                                                        input logic signed [15:0] az,
                                                        input logic [31:0] now,
                                                        input logic clr);
        int          axes [3];
        longint      sq;
        int          v;
        int          mag;
        int          avg;
        int          dev;
        int          thr;
        int          grav;
        logic [31:0] elapsed;
        asd_pkg::t_result res;
        axes[0] = ax;
        axes[1] = ay;
        axes[2] = az;
        sq = 0;
        for (int k = 0; k < 3; k++) begin
            v = axes[k];
            if (v < 0)
                v = -v;
            sq += longint'(v) * v;
        end
        mag = ((sq >> 10) > asd_pkg::MAG_MAX) ? int'(asd_pkg::MAG_MAX) : int'(sq >> 10);

        win_sum = win_sum - win_mag[win_idx] + mag;
        win_mag[win_idx] = mag;
        win_idx = (win_idx + 1) % asd_pkg::WINDOW_LEN_DEF;
        avg = win_sum / asd_pkg::WINDOW_LEN_DEF;

        grav = model_cfg.gravity_offset;
        dev = (avg >= grav) ? avg - grav : grav - avg;
        if (dev < int'(model_cfg.noise_floor))
            dev = model_cfg.noise_floor;

        if (dev > int'(model_cfg.active_level) && active_cnt < int'(asd_pkg::ACTIVE_MAX))
            active_cnt++;

        res.step_seen = 1'b0;
        thr = thr_lvl;
        elapsed = now - prev_step_ms;
        if (dev > thr && armed && elapsed > {16'd0, model_cfg.min_step_gap_ms}) begin
            res.step_seen = 1'b1;
            step_cnt++;
            prev_step_ms = now;
            if (dev > 2 * thr) begin
                thr = thr + model_cfg.raise_amount;
                if (thr > int'(asd_pkg::MAG_MAX))
                    thr = asd_pkg::MAG_MAX;
            end else if (thr > int'(model_cfg.threshold_floor) && dev < (3 * thr) / 2) begin
                thr = (thr > int'(model_cfg.lower_amount)) ? thr - model_cfg.lower_amount : 0;
            end
        end
        thr_lvl = thr;
        // rearm uses the threshold after this sample's update
        armed = dev < (3 * thr) / 4;

        res.steps_total       = step_cnt;
        res.active_total      = active_cnt[7:0];
        res.current_threshold = thr[asd_pkg::MAG_W-1:0];
        res.deviation         = dev[asd_pkg::MAG_W-1:0];
        if (clr) begin
            step_cnt   = '0;
            active_cnt = 0;
        end
        return res;
    endfunction

    task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic signed [15:0] z, input logic [31:0] t,
                               input logic clr, input logic typed,
                               input asd_pkg::t_result typed_res);
        asd_pkg::t_result pred;
        int      gap;
        @(negedge i_clk);
        i_accel_x      = x;
        i_accel_y      = y;
        i_accel_z      = z;
        i_time_ms      = t;
        i_clear_counts = clr;
        i_in_valid     = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pred = predict_sample(x, y, z, t, clr);
        expected_q.push_back(typed ? typed_res : pred);
        gap = tx_fast ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic add_row(input int x, input int y, input int z, input logic [31:0] t,
                           input int clr, input int typed, input int act,
                           input int thr, input int dev);
        t_stim_row row;
        row.x     = 16'(x);
        row.y     = 16'(y);
        row.z     = 16'(z);
        row.t     = t;
        row.clr   = 1'(clr);
        row.typed = 1'(typed);
        // typed rows only occur before any step, so seen and total are zero
        row.res.step_seen         = 1'b0;
        row.res.steps_total       = '0;
        row.res.active_total      = 8'(act);
        row.res.current_threshold = 15'(thr);
        row.res.deviation         = 15'(dev);
        stim_rows.push_back(row);
    endtask

    task automatic write_reg(input logic [asd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [asd_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            asd_pkg::CFG_GRAVITY: model_cfg.gravity_offset  = data[11:0];
            asd_pkg::CFG_NOISE:   model_cfg.noise_floor     = data[11:0];
            asd_pkg::CFG_ACTIVE:  model_cfg.active_level    = data[14:0];
            asd_pkg::CFG_GAP:     model_cfg.min_step_gap_ms = data;
            asd_pkg::CFG_FLOOR:   model_cfg.threshold_floor = data[14:0];
            asd_pkg::CFG_RAISE:   model_cfg.raise_amount    = data[9:0];
            asd_pkg::CFG_LOWER:   model_cfg.lower_amount    = data[9:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input int grav, input int noise, input int act, input int gap,
                                input int flr, input int raise, input int lower);
        write_reg(asd_pkg::CFG_GRAVITY, 16'(grav));
        write_reg(asd_pkg::CFG_NOISE, 16'(noise));
        write_reg(asd_pkg::CFG_ACTIVE, 16'(act));
        write_reg(asd_pkg::CFG_GAP, 16'(gap));
        write_reg(asd_pkg::CFG_FLOOR, 16'(flr));
        write_reg(asd_pkg::CFG_RAISE, 16'(raise));
        write_reg(asd_pkg::CFG_LOWER, 16'(lower));
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain_pipeline;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly gait-like sequences: a baseline near gravity with periodic peaks scaled to
    // the current threshold; some short spacings, time jumps and pure noise mixed in.
    task automatic run_walk(input int count, input int pause_at);
        int   r;
        int   v;
        int   thr;
        int   grav;
        int   ax [3];
        real  level;
        logic clr;
        for (int i = 0; i < count; i++) begin
            if (i == pause_at)
                drain_pipeline();
            r   = $urandom_range(0, 99);
            clr = ($urandom_range(0, 39) == 0);
            if (r < 12) begin
                send_sample(16'($urandom), 16'($urandom), 16'($urandom), $urandom, clr,
                            1'b0, '0);
            end else begin
                if (r < 14)
                    walk_ms = $urandom;
                else if (r < 24)
                    walk_ms = walk_ms + $urandom_range(0, 20);
                else
                    walk_ms = walk_ms + $urandom_range(20, 120);
                thr  = thr_lvl;
                grav = model_cfg.gravity_offset;
                if (walk_pos == 0) begin
                    walk_period   = $urandom_range(6, 16);
                    walk_peak_len = $urandom_range(1, 4);
                    walk_gain     = $urandom_range(40, 320) / 100.0;
                end
                if (walk_pos < walk_peak_len)
                    level = grav + walk_gain * thr * 8.0 / walk_peak_len;
                else
                    level = grav + $urandom_range(0, thr / 4 + 1) - thr / 8.0;
                walk_pos = (walk_pos + 1) % walk_period;
                if (level < 0.0)
                    level = 0.0;
                if (level > 32767.0)
                    level = 32767.0;
                v = int'($sqrt(level * 1024.0));
                if (v > 32767)
                    v = 32767;
                for (int k = 0; k < 3; k++)
                    ax[k] = $urandom_range(0, 80) - 40;
                r = $urandom_range(0, 2);
                ax[r] = $urandom_range(0, 1) ? v : -v;
                send_sample(16'(ax[0]), 16'(ax[1]), 16'(ax[2]), walk_ms, clr, 1'b0, '0);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Result side: random stalls, one long hold-off so the pipeline backs up
    initial begin : result_sink
        int      stall;
        asd_pkg::t_result want;
        i_out_ready = 1'b0;
        rx_fast     = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = rx_fast ? 0 : $urandom_range(0, 9);
            if (results_seen == RX_HOLD_AT)
                stall = RX_HOLD_CYCLES;
            if (stall > 0) begin
                @(negedge i_clk);
                i_out_ready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (expected_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, got deviation %0d",
                         $time, o_deviation);
                errors++;
            end else begin
                want = expected_q.pop_front();
                check_field("step_seen", want.step_seen, o_step_seen);
                check_field("steps_total", want.steps_total, o_steps_total);
                check_field("active_total", want.active_total, o_active_total);
                check_field("current_threshold", want.current_threshold, o_current_threshold);
                check_field("deviation", want.deviation, o_deviation);
            end
            results_seen++;
            if (results_seen % 100 == 0)
                rx_fast = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_accel_x      = '0;
        i_accel_y      = '0;
        i_accel_z      = '0;
        i_time_ms      = '0;
        i_clear_counts = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        tx_fast        = 1'b0;
        errors         = 0;
        results_seen   = 0;
        cycles         = 0;

        model_cfg.gravity_offset  = asd_pkg::GRAVITY_RESET;
        model_cfg.noise_floor     = asd_pkg::NOISE_RESET;
        model_cfg.active_level    = asd_pkg::ACTIVE_RESET;
        model_cfg.min_step_gap_ms = asd_pkg::GAP_RESET;
        model_cfg.threshold_floor = asd_pkg::FLOOR_RESET;
        model_cfg.raise_amount    = asd_pkg::RAISE_RESET;
        model_cfg.lower_amount    = asd_pkg::LOWER_RESET;
        foreach (win_mag[k])
            win_mag[k] = 0;
        win_idx      = 0;
        win_sum      = 0;
        thr_lvl      = asd_pkg::THRESH_RESET;
        prev_step_ms = '0;
        step_cnt     = '0;
        active_cnt   = 0;
        armed        = 1'b0;
        walk_ms      = 32'd5000;
        walk_pos     = 0;

        // Directed rows, reset configuration. Typed rows: fresh state and saturated magnitude.
        add_row(0, 0, 0, 0, 0, 1, 1, 1200, 1000);
        add_row(-32768, -32768, -32768, 10, 0, 1, 2, 1200, 3095);
        add_row(32767, 32767, 32767, 20, 0, 1, 3, 1200, 7191);
        add_row(-32768, 32767, 0, 30, 1, 0, 0, 0, 0);
        // flush the window with 1 g so the detector rearms
        add_row(1012, 0, 0, 100, 0, 0, 0, 0, 0);
        add_row(0, -1012, 0, 200, 0, 0, 0, 0, 0);
        add_row(0, 0, 1012, 300, 0, 0, 0, 0, 0);
        add_row(-1012, 0, 0, 400, 0, 0, 0, 0, 0);
        add_row(1012, 0, 0, 500, 0, 0, 0, 0, 0);
        add_row(0, 1012, 0, 600, 0, 0, 0, 0, 0);
        add_row(0, 0, -1012, 700, 0, 0, 0, 0, 0);
        add_row(1012, 0, 0, 800, 0, 0, 0, 0, 0);
        // strong step, then a repeat inside the minimum gap
        add_row(0, 0, 8000, 1000, 0, 0, 0, 0, 0);
        add_row(0, 0, 8000, 1050, 0, 0, 0, 0, 0);
        add_row(1012, 0, 0, 1100, 0, 0, 0, 0, 0);
        add_row(1012, 0, 0, 1200, 0, 0, 0, 0, 0);
        add_row(0, 1012, 0, 1300, 1, 0, 0, 0, 0);
        add_row(1012, 0, 0, 1400, 0, 0, 0, 0, 0);
        add_row(0, 0, 1012, 1500, 0, 0, 0, 0, 0);
        add_row(1012, 0, 0, 1600, 0, 0, 0, 0, 0);
        // moderate peaks for a weak step, then timestamps across the 2^32 wrap
        add_row(0, 0, 3000, 32'hFFFF_FF00, 0, 0, 0, 0, 0);
        add_row(0, 0, 3000, 32'hFFFF_FFF0, 0, 0, 0, 0, 0);
        add_row(1012, 0, 0, 32'h0000_0010, 0, 0, 0, 0, 0);
        add_row(-6000, 0, 0, 32'h0000_0200, 0, 0, 0, 0, 0);
        add_row(32'sh5555, -32'sh5556, 32'sh5555, 32'hAAAA_5555, 1, 0, 0, 0, 0);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                drain_pipeline();
                if (phase == 1 || phase == 6)
                    write_reg(CFG_SPARE_IDX, 16'($urandom));
                case (phase)
                    1: program_regs(0, 0, 0, 0, 0, 0, 0);
                    2: program_regs(4095, 4095, 32767, 65535, 32767, 1023, 1023);
                    9: program_regs($urandom_range(0, 4095), $urandom_range(0, 4095),
                                    $urandom_range(0, 32767), $urandom_range(0, 65535),
                                    $urandom_range(0, 32767), $urandom_range(0, 1023),
                                    $urandom_range(0, 1023));
                    default: program_regs($urandom_range(700, 1300), $urandom_range(0, 400),
                                          $urandom_range(0, 2500), $urandom_range(0, 600),
                                          $urandom_range(0, 2500), $urandom_range(0, 1023),
                                          $urandom_range(0, 1023));
                endcase
            end else begin
                foreach (stim_rows[i])
                    send_sample(stim_rows[i].x, stim_rows[i].y, stim_rows[i].z, stim_rows[i].t,
                                stim_rows[i].clr, stim_rows[i].typed, stim_rows[i].res);
            end
            tx_fast = ($urandom_range(0, 3) == 0);
            run_walk(ITEMS_PER_PHASE, (phase == 4) ? ITEMS_PER_PHASE / 2 : -1);
        end
        drain_pipeline();

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
